>>> sv/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg
// shared constants and types for the longest simple path search unit
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int unsigned MaxVertices = 16;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = $clog2(MaxVertices + 1);

  typedef logic [VtxW-1:0] vtx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [MaxVertices-1:0] row_t;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [0:0] RegVertexCount = 1'b0;

endpackage

>>> sv/longest_simple_path_search_unit.sv
// ----------------------------------------------------------------------------
// longest_simple_path_search_unit
// exhaustive backtracking search for the longest simple path in a small graph
// ----------------------------------------------------------------------------
// adjacency write: row read, then row write; no result
// query: a push runs stack write, stack read, row read, scan; a pop runs stack
//   read, row read, scan; new best: read, write per entry; exponential at worst
// per result: read, emit; one item at a time, the last result may still wait
// async active-low reset: vertex_count 16, adjacency cleared via row valid bits
module longest_simple_path_search_unit
  import lsps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: op[0], from_vertex[4:1], to_vertex[8:5], edge_present[9]
  input  logic [15:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: vertex[3:0], found[4]
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_PUSH, S_READ, S_ROW, S_SCAN, S_COPY_RD, S_COPY_WR, S_OUT_RD, S_OUT,
    S_NONE
  } state_e;

  state_e state_q;
  logic [4:0] vcount_q;
  row_t adj_mem [MaxVertices];
  row_t adj_valid_q;
  row_t visited_q;
  vtx_t path_mem [MaxVertices];
  cnt_t cur_mem  [MaxVertices];
  vtx_t best_mem [MaxVertices];
  cnt_t depth_q, best_len_q, idx_q, n_q;
  vtx_t dest_q, wv_q;
  vtx_t wr_row_q, wr_col_q;
  logic wr_bit_q;
  vtx_t path_rd_q, best_rd_q;
  cnt_t cur_rd_q;
  row_t row_rd_q;
  logic rv_q;
  logic [3:0] out_v_q;
  logic out_f_q, out_l_q, out_valid_q;

  logic in_xfer, out_xfer, cfg_wr;
  logic       in_op, in_ep;
  vtx_t       in_from, in_to;
  assign in_op   = s_axis_tdata_i[0];
  assign in_from = s_axis_tdata_i[4:1];
  assign in_to   = s_axis_tdata_i[8:5];
  assign in_ep   = s_axis_tdata_i[9];
  assign in_xfer  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_xfer = out_valid_q & m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegVertexCount) ? {27'd0, vcount_q} : 32'd0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_f_q, out_v_q};
  assign m_axis_tlast_o  = out_l_q;

  // scan: first candidate neighbor at or above cursor
  row_t row_eff, cand;
  logic [CntW:0] nlim;
  logic hit;
  vtx_t hit_w;
  always_comb begin
    row_eff = rv_q ? row_rd_q : '0;
    cand = '0;
    hit = 1'b0;
    hit_w = '0;
    for (int i = 0; i < MaxVertices; i++) begin
      cand[i] = row_eff[i] & ~visited_q[i] & (CntW'(i) >= cur_rd_q) & (CntW'(i) < n_q)
                & (VtxW'(i) != path_rd_q);
    end
    for (int i = MaxVertices - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit = 1'b1;
        hit_w = VtxW'(i);
      end
    end
    nlim = {1'b0, depth_q};
  end

  logic [4:0] n_act;
  assign n_act = (vcount_q > 5'(MaxVertices)) ? 5'(MaxVertices) : vcount_q;

  // memories
  logic adj_we;
  vtx_t adj_row_addr;
  row_t adj_wdata;
  always_comb begin
    adj_wdata = row_eff;
    adj_wdata[wr_col_q] = wr_bit_q;
  end
  assign adj_we = (state_q == S_WR);
  assign adj_row_addr = (state_q == S_IDLE) ? in_from : path_rd_q;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[wr_row_q] <= adj_wdata;
    row_rd_q <= adj_mem[adj_row_addr];
  end

  logic path_we, cur_we;
  vtx_t path_waddr, cur_waddr, path_raddr;
  vtx_t path_wdata;
  cnt_t cur_wdata;
  logic best_we;
  vtx_t best_raddr;

  always_ff @(posedge clk_i) begin
    if (path_we) path_mem[path_waddr] <= path_wdata;
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    if (best_we) best_mem[idx_q[VtxW-1:0]] <= path_rd_q;
    path_rd_q <= path_mem[path_raddr];
    cur_rd_q  <= cur_mem[path_raddr];
    best_rd_q <= best_mem[best_raddr];
  end

  cnt_t top;
  assign top = depth_q - 1'b1;

  always_comb begin
    path_we = 1'b0; path_waddr = depth_q[VtxW-1:0]; path_wdata = wv_q;
    cur_we = 1'b0; cur_waddr = depth_q[VtxW-1:0]; cur_wdata = '0;
    path_raddr = top[VtxW-1:0];
    best_we = (state_q == S_COPY_WR);
    best_raddr = idx_q[VtxW-1:0];
    unique case (state_q)
      S_PUSH: begin
        path_we = 1'b1;
        cur_we = 1'b1;
        cur_wdata = (wv_q == dest_q) ? CntW'(MaxVertices) : '0;
      end
      S_SCAN: begin
        if (hit && nlim < MaxVertices) begin
          cur_we = 1'b1;
          cur_waddr = top[VtxW-1:0];
          cur_wdata = CntW'(hit_w) + 1'b1;
        end
      end
      S_COPY_RD: path_raddr = idx_q[VtxW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcount_q <= 5'd16;
      adj_valid_q <= '0;
      visited_q <= '0;
      depth_q <= '0;
      best_len_q <= '0;
      idx_q <= '0;
      n_q <= '0;
      dest_q <= '0;
      wv_q <= '0;
      wr_row_q <= '0;
      wr_col_q <= '0;
      wr_bit_q <= 1'b0;
      rv_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_v_q <= '0;
      out_f_q <= 1'b0;
      out_l_q <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == RegVertexCount) vcount_q <= pwdata[4:0];
      if (adj_we) adj_valid_q[wr_row_q] <= 1'b1;
      if (out_xfer) out_valid_q <= 1'b0;
      rv_q <= adj_valid_q[adj_row_addr];
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_op == OpQuery) begin
              n_q <= n_act;
              dest_q <= in_to;
              wv_q <= in_from;
              visited_q <= '0;
              depth_q <= '0;
              best_len_q <= '0;
              if ({1'b0, in_from} >= n_act || {1'b0, in_to} >= n_act) state_q <= S_NONE;
              else state_q <= S_PUSH;
            end else begin
              wr_row_q <= in_from;
              wr_col_q <= in_to;
              wr_bit_q <= in_ep;
              state_q <= S_WR;
            end
          end
        end
        S_WR: state_q <= S_IDLE;
        S_PUSH: begin
          visited_q[wv_q] <= 1'b1;
          depth_q <= depth_q + 1'b1;
          if (wv_q == dest_q && depth_q + 1'b1 > best_len_q) begin
            best_len_q <= depth_q + 1'b1;
            idx_q <= '0;
            state_q <= S_COPY_RD;
          end else begin
            state_q <= S_READ;
          end
        end
        S_COPY_RD: state_q <= S_COPY_WR;
        S_COPY_WR: begin
          if (idx_q + 1'b1 == depth_q) state_q <= S_READ;
          else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_COPY_RD;
          end
        end
        S_READ: begin
          if (depth_q == '0) begin
            idx_q <= '0;
            state_q <= (best_len_q == '0) ? S_NONE : S_OUT_RD;
          end else begin
            state_q <= S_ROW;
          end
        end
        S_ROW: state_q <= S_SCAN;
        S_SCAN: begin
          if (hit && nlim < MaxVertices) begin
            wv_q <= hit_w;
            state_q <= S_PUSH;
          end else begin
            visited_q[path_rd_q] <= 1'b0;
            depth_q <= depth_q - 1'b1;
            state_q <= S_READ;
          end
        end
        S_OUT_RD: if (!out_valid_q || out_xfer) state_q <= S_OUT;
        S_OUT: begin
          out_valid_q <= 1'b1;
          out_v_q <= best_rd_q;
          out_f_q <= 1'b1;
          out_l_q <= (idx_q + 1'b1 == best_len_q);
          if (idx_q + 1'b1 == best_len_q) state_q <= S_IDLE;
          else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_OUT_RD;
          end
        end
        S_NONE: begin
          if (!out_valid_q || out_xfer) begin
            out_valid_q <= 1'b1;
            out_v_q <= '0;
            out_f_q <= 1'b0;
            out_l_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lsps_checker.sv
// ----------------------------------------------------------------------------
// lsps_checker
// port-level checks for the longest simple path search unit
// ----------------------------------------------------------------------------
module lsps_checker
  import lsps_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  a_nofound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[4] |-> m_axis_tlast_o)
    else $error("no-path result not marked last");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken again right after a transfer");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

endmodule

bind longest_simple_path_search_unit lsps_checker u_lsps_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o)
);
